// ----- design/ensc_pkg.sv -----
package ensc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_CAL_TEMP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_PRESS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_PRESS_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_PRESS_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_HUM_A   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_HUM_B   = 3'd5;

  localparam int DIV_STEPS = 32;
  localparam int TEMP_LAT  = 4;
  localparam int HUM_LAT   = 11;
  localparam int PRESS_LAT = 11 + DIV_STEPS;

  localparam logic signed [31:0] HUM_T_OFS    = 32'sd76800;
  localparam logic signed [31:0] HUM_CLAMP    = 32'sd419430400;
  localparam logic signed [31:0] PRESS_BASE   = 32'sd1048576;
  localparam logic signed [31:0] PRESS_SCALE  = 32'sd3125;
  localparam logic signed [31:0] PRESS_T_OFS  = 32'sd64000;
  localparam logic signed [31:0] HUM_D_OFS    = 32'sd2097152;
  localparam logic signed [31:0] HUM_A_RND    = 32'sd16384;
  localparam logic signed [31:0] ONE_Q15      = 32'sd32768;
  localparam logic signed [31:0] HUM_E_RND    = 32'sd8192;
  localparam logic [9:0]         HUM_MILLI    = 10'd1000;

  typedef struct packed {
    logic [7:0] press_msb;
    logic [7:0] press_lsb;
    logic [7:0] press_xlsb;
    logic [7:0] temp_msb;
    logic [7:0] temp_lsb;
    logic [7:0] temp_xlsb;
    logic [7:0] hum_msb;
    logic [7:0] hum_lsb;
  } burst_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_pa;
    logic [16:0]        humidity_milli;
  } result_t;

  typedef struct packed {
    logic [47:0] cal_temp;
    logic [47:0] cal_press_a;
    logic [47:0] cal_press_b;
    logic [47:0] cal_press_c;
    logic [31:0] cal_hum_a;
    logic [31:0] cal_hum_b;
  } cal_t;

  typedef struct packed {
    logic signed [31:0] tf;
    logic signed [31:0] temp;
    logic [19:0]        adc_p;
    logic [15:0]        adc_h;
  } temp_res_t;

  typedef struct packed {
    logic zero;
    logic hi;
  } div_tag_t;

  function automatic logic signed [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic signed [31:0] sx12(input logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  function automatic logic signed [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage

// ----- design/ensc_temp.sv -----
module ensc_temp (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  ensc_pkg::burst_t   burst,
  input  ensc_pkg::cal_t     cal,
  output logic               out_vld,
  output ensc_pkg::temp_res_t out
);
  import ensc_pkg::*;

  logic [19:0] adc_t;
  logic signed [31:0] t1, t2, t3, d1, x1;
  logic [TEMP_LAT-1:0] vld;
  logic signed [31:0] m1, xx1, a2, b2, tf3, tf4, temp4;
  logic [19:0] ap1, ap2, ap3, ap4;
  logic [15:0] ah1, ah2, ah3, ah4;

  always_comb begin
    adc_t = {burst.temp_msb, burst.temp_lsb, burst.temp_xlsb[7:4]};
    t1 = {16'b0, cal.cal_temp[15:0]};
    t2 = sx16(cal.cal_temp[31:16]);
    t3 = sx16(cal.cal_temp[47:32]);
    d1 = $signed({15'b0, adc_t[19:3]}) - (t1 <<< 1);
    x1 = $signed({16'b0, adc_t[19:4]}) - t1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[TEMP_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    m1    <= d1 * t2;
    xx1   <= x1 * x1;
    ap1   <= {burst.press_msb, burst.press_lsb, burst.press_xlsb[7:4]};
    ah1   <= {burst.hum_msb, burst.hum_lsb};
    a2    <= m1 >>> 11;
    b2    <= (xx1 >>> 12) * t3;
    ap2   <= ap1;
    ah2   <= ah1;
    tf3   <= a2 + (b2 >>> 14);
    ap3   <= ap2;
    ah3   <= ah2;
    tf4   <= tf3;
    temp4 <= (tf3 + (tf3 <<< 2) + 32'sd128) >>> 8;
    ap4   <= ap3;
    ah4   <= ah3;
  end

  assign out_vld   = vld[TEMP_LAT-1];
  assign out.tf    = tf4;
  assign out.temp  = temp4;
  assign out.adc_p = ap4;
  assign out.adc_h = ah4;

endmodule

// ----- design/ensc_hum.sv -----
module ensc_hum (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  ensc_pkg::temp_res_t tin,
  input  ensc_pkg::cal_t      cal,
  output logic                out_vld,
  output logic [16:0]         hum
);
  import ensc_pkg::*;

  logic signed [31:0] h1, h2, h3, h4, h5, h6;
  logic [HUM_LAT-1:0] vld;
  logic signed [31:0] v1, m5, m6, m3, a3, b3, c3, a4, bc4, a5, dh5, a6, e6;
  logic signed [31:0] v7, v8, xx8, v9, t9, x7, w;
  logic [15:0] ah1, ah2;
  logic [16:0] v10;
  logic [26:0] prod;

  always_comb begin
    h1 = {24'b0, cal.cal_hum_a[7:0]};
    h2 = sx16(cal.cal_hum_a[23:8]);
    h3 = {24'b0, cal.cal_hum_a[31:24]};
    h4 = sx12(cal.cal_hum_b[11:0]);
    h5 = sx12(cal.cal_hum_b[23:12]);
    h6 = sx8(cal.cal_hum_b[31:24]);
    x7 = v7 >>> 15;
    w = v9 - (t9 >>> 4);
    prod = 27'(v10) * 27'(HUM_MILLI);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[HUM_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    v1  <= tin.tf - HUM_T_OFS;
    ah1 <= tin.adc_h;
    m5  <= h5 * v1;
    m6  <= v1 * h6;
    m3  <= v1 * h3;
    ah2 <= ah1;
    a3  <= ($signed({2'b0, ah2, 14'b0}) - (h4 <<< 20) - m5 + HUM_A_RND) >>> 15;
    b3  <= m6 >>> 10;
    c3  <= (m3 >>> 11) + ONE_Q15;
    a4  <= a3;
    bc4 <= b3 * c3;
    a5  <= a4;
    dh5 <= ((bc4 >>> 10) + HUM_D_OFS) * h2;
    a6  <= a5;
    e6  <= (dh5 + HUM_E_RND) >>> 14;
    v7  <= a6 * e6;
    v8  <= v7;
    xx8 <= x7 * x7;
    v9  <= v8;
    t9  <= (xx8 >>> 7) * h1;
    if (w[31]) begin
      v10 <= '0;
    end else if ($unsigned(w) > $unsigned(HUM_CLAMP)) begin
      v10 <= HUM_CLAMP[28:12];
    end else begin
      v10 <= w[28:12];
    end
    hum <= prod[26:10];
  end

  assign out_vld = vld[HUM_LAT-1];

endmodule

// ----- design/ensc_div.sv -----
module ensc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  logic [31:0]        num,
  input  logic [31:0]        den,
  input  ensc_pkg::div_tag_t tag,
  output logic               out_vld,
  output logic [31:0]        quot,
  output ensc_pkg::div_tag_t out_tag
);
  import ensc_pkg::*;

  logic               vld [DIV_STEPS];
  logic [31:0]        rem [DIV_STEPS];
  logic [31:0]        nq  [DIV_STEPS];
  logic [31:0]        dd  [DIV_STEPS];
  div_tag_t           tg  [DIV_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic        v_in;
    logic [31:0] r_in, n_in, d_in;
    div_tag_t    t_in;
    logic [32:0] tr, diff;
    logic        ge;

    if (i == 0) begin : g_first
      assign v_in = in_vld;
      assign r_in = '0;
      assign n_in = num;
      assign d_in = den;
      assign t_in = tag;
    end else begin : g_next
      assign v_in = vld[i-1];
      assign r_in = rem[i-1];
      assign n_in = nq[i-1];
      assign d_in = dd[i-1];
      assign t_in = tg[i-1];
    end

    assign tr   = {r_in, n_in[31]};
    assign diff = tr - {1'b0, d_in};
    assign ge   = tr >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem[i] <= ge ? diff[31:0] : tr[31:0];
      nq[i]  <= {n_in[30:0], ge};
      dd[i]  <= d_in;
      tg[i]  <= t_in;
    end
  end

  assign out_vld = vld[DIV_STEPS-1];
  assign quot    = nq[DIV_STEPS-1];
  assign out_tag = tg[DIV_STEPS-1];

endmodule

// ----- design/ensc_press.sv -----
module ensc_press (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  ensc_pkg::temp_res_t tin,
  input  ensc_pkg::cal_t      cal,
  output logic                out_vld,
  output logic [31:0]         pres
);
  import ensc_pkg::*;

  logic signed [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, q2;
  logic [6:0] vld;
  logic [3:0] pvld;
  logic signed [31:0] v1, sq2, m52, m22, v2a3, p3s3, m53, m23, v24, v1b4;
  logic signed [31:0] m5, n5, dv6, pr6, bm, am, bb;
  logic [19:0] ap1, ap2, ap3, ap4;
  logic [31:0] num7, den7, quot, pr0, pr1, pr2, sq;
  div_tag_t tag7, dtag;
  logic zero0, zero1, zero2, dvld;

  always_comb begin
    p1 = {16'b0, cal.cal_press_a[15:0]};
    p2 = sx16(cal.cal_press_a[31:16]);
    p3 = sx16(cal.cal_press_a[47:32]);
    p4 = sx16(cal.cal_press_b[15:0]);
    p5 = sx16(cal.cal_press_b[31:16]);
    p6 = sx16(cal.cal_press_b[47:32]);
    p7 = sx16(cal.cal_press_c[15:0]);
    p8 = sx16(cal.cal_press_c[31:16]);
    p9 = sx16(cal.cal_press_c[47:32]);
    q2 = v1 >>> 2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      pvld <= '0;
    end else begin
      vld  <= {vld[5:0], in_vld};
      pvld <= {pvld[2:0], dvld};
    end
  end

  always_ff @(posedge clk) begin
    v1   <= (tin.tf >>> 1) - PRESS_T_OFS;
    ap1  <= tin.adc_p;
    sq2  <= q2 * q2;
    m52  <= v1 * p5;
    m22  <= p2 * v1;
    ap2  <= ap1;
    v2a3 <= (sq2 >>> 11) * p6;
    p3s3 <= p3 * (sq2 >>> 13);
    m53  <= m52;
    m23  <= m22;
    ap3  <= ap2;
    v24  <= ((v2a3 + (m53 <<< 1)) >>> 2) + (p4 <<< 16);
    v1b4 <= ((p3s3 >>> 3) + (m23 >>> 1)) >>> 18;
    ap4  <= ap3;
    m5   <= (ONE_Q15 + v1b4) * p1;
    n5   <= PRESS_BASE - $signed({12'b0, ap4}) - (v24 >>> 12);
    dv6  <= m5 >>> 15;
    pr6  <= n5 * PRESS_SCALE;
    if (pr6[31]) begin
      num7    <= pr6;
      tag7.hi <= 1'b1;
    end else begin
      num7    <= {pr6[30:0], 1'b0};
      tag7.hi <= 1'b0;
    end
    den7      <= dv6;
    tag7.zero <= dv6 == 32'sd0;
  end

  ensc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (vld[6]),
    .num     (num7),
    .den     (den7),
    .tag     (tag7),
    .out_vld (dvld),
    .quot    (quot),
    .out_tag (dtag)
  );

  always_ff @(posedge clk) begin
    pr0   <= dtag.hi ? {quot[30:0], 1'b0} : quot;
    zero0 <= dtag.zero;
    sq    <= {3'b0, pr0[31:3]} * {3'b0, pr0[31:3]};
    bm    <= $signed({2'b0, pr0[31:2]}) * p8;
    pr1   <= pr0;
    zero1 <= zero0;
    am    <= p9 * $signed({13'b0, sq[31:13]});
    bb    <= bm >>> 13;
    pr2   <= pr1;
    zero2 <= zero1;
    pres  <= zero2 ? '0 : pr2 + $unsigned(((am >>> 12) + bb + p7) >>> 4);
  end

  assign out_vld = pvld[3];

endmodule

// ----- design/env_sensor_compensation.sv -----
// Compensates one eight-byte raw burst per clock into temperature in 0.01 degC,
// pressure in Pa and humidity in milli-percent. The block is fully pipelined:
// busy is always low, a new item may start in every cycle, and each result
// appears with done after passing through the 4-stage temperature front end,
// the 7 pressure setup stages, the 32-stage one-bit-per-stage pressure
// divider and 4 final pressure stages. The receiver cannot stall, so results
// must be taken in the cycle that done is high.
// Calibration registers may only be written while no item is in flight.
module env_sensor_compensation (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  ensc_pkg::burst_t                  burst,
  output logic                              done,
  output ensc_pkg::result_t                 result,
  input  logic                              cfg_we,
  input  logic [ensc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [ensc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ensc_pkg::*;

  cal_t cal;
  logic t_vld, h_vld, p_vld;
  temp_res_t t_out;
  logic [16:0] h_out;
  logic [31:0] p_out;
  logic signed [31:0] tdly [PRESS_LAT];
  logic [16:0] hdly [PRESS_LAT-HUM_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CAL_TEMP:    cal.cal_temp    <= cfg_data;
        REG_CAL_PRESS_A: cal.cal_press_a <= cfg_data;
        REG_CAL_PRESS_B: cal.cal_press_b <= cfg_data;
        REG_CAL_PRESS_C: cal.cal_press_c <= cfg_data;
        REG_CAL_HUM_A:   cal.cal_hum_a   <= cfg_data[31:0];
        REG_CAL_HUM_B:   cal.cal_hum_b   <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  assign busy = 1'b0;

  ensc_temp u_temp (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (start),
    .burst   (burst),
    .cal     (cal),
    .out_vld (t_vld),
    .out     (t_out)
  );

  ensc_hum u_hum (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (t_vld),
    .tin     (t_out),
    .cal     (cal),
    .out_vld (h_vld),
    .hum     (h_out)
  );

  ensc_press u_press (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (t_vld),
    .tin     (t_out),
    .cal     (cal),
    .out_vld (p_vld),
    .pres    (p_out)
  );

  always_ff @(posedge clk) begin
    tdly[0] <= t_out.temp;
    for (int i = 1; i < PRESS_LAT; i++) begin
      tdly[i] <= tdly[i-1];
    end
    hdly[0] <= h_out;
    for (int i = 1; i < PRESS_LAT - HUM_LAT; i++) begin
      hdly[i] <= hdly[i-1];
    end
  end

  assign done                     = p_vld;
  assign result.temperature_centi = tdly[PRESS_LAT-1];
  assign result.pressure_pa       = p_out;
  assign result.humidity_milli    = hdly[PRESS_LAT-HUM_LAT-1];

  a_temp_to_done: assert property (@(posedge clk) disable iff (rst)
    t_vld |-> ##43 done) else $error("temperature item did not reach the output");

  a_hum_to_done: assert property (@(posedge clk) disable iff (rst)
    h_vld |-> ##32 done) else $error("humidity item misaligned with pressure");

  a_start_to_hum: assert property (@(posedge clk) disable iff (rst)
    start |-> ##15 h_vld) else $error("humidity stage lost an item");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.humidity_milli <= 17'd100000) else $error("humidity out of range");

endmodule

// ----- tb/sv/ensc_checker.sv -----
module ensc_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  ensc_pkg::burst_t                burst,
  input  logic                            done,
  input  ensc_pkg::result_t               result,
  input  logic                            cfg_we,
  input  logic [ensc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ensc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              checked_count
);
  import ensc_pkg::*;

  logic [47:0] c_temp, c_pa, c_pb, c_pc;
  logic [31:0] c_ha, c_hb;
  result_t expected_readings[$];

  function automatic logic [31:0] asr(input logic [31:0] v, input int n);
    return $signed(v) >>> n;
  endfunction

  function automatic result_t compensate(input burst_t b);
    logic [31:0] adc_t, adc_p, adc_h;
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [31:0] a, bb, c, d, e, v, x, tf, sq, q, v1, v2, pres, pp;
    result_t r;
    adc_t = {12'd0, b.temp_msb, b.temp_lsb, b.temp_xlsb[7:4]};
    adc_p = {12'd0, b.press_msb, b.press_lsb, b.press_xlsb[7:4]};
    adc_h = {16'd0, b.hum_msb, b.hum_lsb};
    t1 = {16'd0, c_temp[15:0]};
    t2 = {{16{c_temp[31]}}, c_temp[31:16]};
    t3 = {{16{c_temp[47]}}, c_temp[47:32]};
    p1 = {16'd0, c_pa[15:0]};
    p2 = {{16{c_pa[31]}}, c_pa[31:16]};
    p3 = {{16{c_pa[47]}}, c_pa[47:32]};
    p4 = {{16{c_pb[15]}}, c_pb[15:0]};
    p5 = {{16{c_pb[31]}}, c_pb[31:16]};
    p6 = {{16{c_pb[47]}}, c_pb[47:32]};
    p7 = {{16{c_pc[15]}}, c_pc[15:0]};
    p8 = {{16{c_pc[31]}}, c_pc[31:16]};
    p9 = {{16{c_pc[47]}}, c_pc[47:32]};
    h1 = {24'd0, c_ha[7:0]};
    h2 = {{16{c_ha[23]}}, c_ha[23:8]};
    h3 = {24'd0, c_ha[31:24]};
    h4 = {{20{c_hb[11]}}, c_hb[11:0]};
    h5 = {{20{c_hb[23]}}, c_hb[23:12]};
    h6 = {{24{c_hb[31]}}, c_hb[31:24]};

    v = asr(adc_t, 3) - (t1 << 1);
    a = asr(v * t2, 11);
    x = asr(adc_t, 4) - t1;
    v = x * x;
    v = asr(v, 12) * t3;
    bb = asr(v, 14);
    tf = a + bb;
    v = tf * 32'd5 + 32'd128;
    r.temperature_centi = asr(v, 8);

    v = tf - 32'd76800;
    a = (adc_h << 14) - (h4 << 20) - h5 * v;
    a = asr(a + 32'd16384, 15);
    bb = asr(v * h6, 10);
    c = asr(v * h3, 11) + 32'd32768;
    d = asr(bb * c, 10) + 32'd2097152;
    e = asr(d * h2 + 32'd8192, 14);
    v = a * e;
    x = asr(v, 15);
    pp = x * x;
    pp = asr(pp, 7) * h1;
    v = v - asr(pp, 4);
    if (v[31]) v = 0;
    if (v > 32'd419430400) v = 32'd419430400;
    v = v >> 12;
    v = v * 32'd1000;
    r.humidity_milli = 17'(v >> 10);

    v1 = asr(tf, 1) - 32'd64000;
    q = asr(v1, 2);
    sq = q * q;
    v2 = asr(sq, 11) * p6;
    pp = v1 * p5;
    v2 = v2 + (pp << 1);
    v2 = asr(v2, 2) + (p4 << 16);
    pp = p3 * asr(sq, 13);
    v1 = asr(asr(pp, 3) + asr(p2 * v1, 1), 18);
    v1 = asr((32'd32768 + v1) * p1, 15);
    if (v1 == 0) begin
      pres = 0;
    end else begin
      pres = ((32'd1048576 - adc_p) - asr(v2, 12)) * 32'd3125;
      if (pres < 32'h80000000) pres = (pres << 1) / v1;
      else pres = (pres / v1) << 1;
      pp = (pres >> 3) * (pres >> 3);
      pp = pp >> 13;
      a = asr(p9 * pp, 12);
      bb = asr((pres >> 2) * p8, 13);
      pres = pres + asr(a + bb + p7, 4);
    end
    r.pressure_pa = pres;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      c_temp <= '0; c_pa <= '0; c_pb <= '0; c_pc <= '0; c_ha <= '0; c_hb <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_CAL_TEMP: c_temp <= cfg_data;
          REG_CAL_PRESS_A: c_pa <= cfg_data;
          REG_CAL_PRESS_B: c_pb <= cfg_data;
          REG_CAL_PRESS_C: c_pc <= cfg_data;
          REG_CAL_HUM_A: c_ha <= cfg_data[31:0];
          REG_CAL_HUM_B: c_hb <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (start && !busy) expected_readings.push_back(compensate(burst));
      if (done) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected item", 0, 0);
        end else begin
          want = expected_readings.pop_front();
          checked_count++;
          if (result.temperature_centi !== want.temperature_centi)
            report_mismatch("temperature_centi", result.temperature_centi,
                            want.temperature_centi);
          if (result.pressure_pa !== want.pressure_pa)
            report_mismatch("pressure_pa", result.pressure_pa, want.pressure_pa);
          if (result.humidity_milli !== want.humidity_milli)
            report_mismatch("humidity_milli", 32'(result.humidity_milli),
                            32'(want.humidity_milli));
        end
      end
    end
    pending <= expected_readings.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    checked_count = 0;
  end
endmodule

// ----- tb/sv/tb_env_sensor_compensation.sv -----
module tb_env_sensor_compensation;
  import ensc_pkg::*;

  logic clk, rst, start, busy, done, cfg_we;
  burst_t burst;
  result_t result;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fail_count, pending, checked_count, sent, cycles;
  logic [47:0] cal_vals[6];

  env_sensor_compensation dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .burst(burst), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  ensc_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .burst(burst), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .checked_count(checked_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 200000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic burst_t pack_burst(input logic [19:0] p, input logic [19:0] t,
                                        input logic [15:0] h);
    burst_t b;
    b.press_msb = p[19:12]; b.press_lsb = p[11:4];
    b.press_xlsb = {p[3:0], 4'($urandom)};
    b.temp_msb = t[19:12]; b.temp_lsb = t[11:4];
    b.temp_xlsb = {t[3:0], 4'($urandom)};
    b.hum_msb = h[15:8]; b.hum_lsb = h[7:0];
    return b;
  endfunction

  function automatic burst_t random_burst();
    if ($urandom_range(0, 3) == 0) return burst_t'({$urandom, $urandom});
    return pack_burst(20'(415148 + $urandom_range(0, 200000) - 100000),
                      20'(519888 + $urandom_range(0, 80000) - 40000),
                      16'($urandom_range(10000, 50000)));
  endfunction

  task automatic send_item(input burst_t b, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    burst <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (PRESS_LAT + 5) @(negedge clk);
  endtask

  task automatic write_cal(input int mode);
    logic [CFG_IDX_W-1:0] idx[6];
    idx = '{REG_CAL_TEMP, REG_CAL_PRESS_A, REG_CAL_PRESS_B, REG_CAL_PRESS_C,
            REG_CAL_HUM_A, REG_CAL_HUM_B};
    case (mode)
      0: cal_vals = '{{16'hFC18, 16'd26435, 16'd27504},
                      {16'd3024, 16'hD643, 16'd36477},
                      {16'hFFF9, 16'd140, 16'd2855},
                      {16'd6000, 16'hC6F8, 16'd15500},
                      {16'd0, 8'd0, 16'd362, 8'd75},
                      {16'd0, 8'd30, 12'd50, 12'd313}};
      1: cal_vals = '{default: '0};
      2: cal_vals = '{default: '1};
      default: foreach (cal_vals[i]) cal_vals[i] = rand48();
    endcase
    if (mode == 4) begin
      cal_vals[0][15:0] = 16'd27504 + 16'($urandom_range(0, 2000));
      cal_vals[1][15:0] = 16'd36477 + 16'($urandom_range(0, 2000));
    end
    foreach (idx[i]) begin
      cfg_we <= 1'b1;
      cfg_idx <= idx[i];
      cfg_data <= cal_vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [19:0] ext[2];
    int gap_max;
    start = 0; burst = '0; cfg_we = 0; cfg_idx = '0; cfg_data = '0;
    sent = 0; cycles = 0;
    rst = 1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_item('0, 0);
    drain();
    write_cal(0);
    ext = '{20'h00000, 20'hFFFFF};
    foreach (ext[i]) foreach (ext[j]) begin
      send_item(pack_burst(ext[i], ext[j], 16'h0000), 0);
      send_item(pack_burst(ext[i], ext[j], 16'hFFFF), 1);
    end
    send_item('1, 0);
    send_item(burst_t'(64'h00_00_0F_00_00_0F_00_00), 0);
    send_item(pack_burst(20'd415148, 20'd519888, 16'd30000), 2);
    send_item(pack_burst(20'd415148, 20'd519888, 16'd0), 0);
    send_item(pack_burst(20'd415148, 20'd519888, 16'hFFFF), 0);
    send_item(pack_burst(20'd415148, 20'd300000, 16'd40000), 0);
    send_item(pack_burst(20'd415148, 20'd700000, 16'd20000), 3);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_cal(ph);
      for (int k = 0; k < 125; k++) begin
        gap_max = (k / 25) % 2 ? 0 : 3;
        send_item(random_burst(), $urandom_range(0, gap_max));
      end
    end

    drain();
    $display("Sent %0d items over six calibration sets (typical, zero, all-ones, random).",
             sent);
    $display("Checked %0d results, including the zero-divisor pressure case.",
             checked_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
